>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge while reset is released
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every rising edge, reset included
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared constants, codes and types of the paletted texel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

  localparam int INDEX_W = 8;
  localparam int WORD_W  = 16;
  localparam int COLOR_W = 15;
  localparam int CHAN_W  = 8;

  localparam logic [INDEX_W:0] PAL_DEPTH_W = (INDEX_W + 1)'(PALETTE_DEPTH);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXEL_FORMAT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_ZERO_CLEAR = 1'b1;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

  typedef enum logic {
    OP_PAL_WRITE = 1'b0,
    OP_DECODE    = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    FMT_A3I5   = 3'd1,
    FMT_2BPP   = 3'd2,
    FMT_4BPP   = 3'd3,
    FMT_8BPP   = 3'd4,
    FMT_A5I3   = 3'd6,
    FMT_DIRECT = 3'd7
  } texel_fmt_t;

  typedef struct packed {
    logic                en;
    logic [PAL_AW-1:0]   addr;
    logic [COLOR_W-1:0]  data;
  } pal_wr_t;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
  } pal_rd_t;

endpackage

`default_nettype wire

>>> src/ptd_if.sv
// ----------------------------------------------------------------------------
// ptd channel interfaces
// Valid/ready request channels for texel items and decoded pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [ptd_pkg::INDEX_W-1:0]  entry_index;
  logic [ptd_pkg::WORD_W-1:0]   data_word;

  modport source (output valid, output opcode, output entry_index, output data_word,
                  input ready);
  modport sink   (input valid, input opcode, input entry_index, input data_word,
                  output ready);
endinterface

interface ptd_out_if;
  logic                        valid;
  logic                        ready;
  logic [ptd_pkg::CHAN_W-1:0]  red;
  logic [ptd_pkg::CHAN_W-1:0]  green;
  logic [ptd_pkg::CHAN_W-1:0]  blue;
  logic [ptd_pkg::CHAN_W-1:0]  alpha;
  logic                        run_end;
  logic                        format_error;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output run_end, output format_error, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input run_end, input format_error, output ready);
endinterface

`default_nettype wire

>>> src/ptd_palette_ram.sv
// ----------------------------------------------------------------------------
// ptd_palette_ram
// Palette color store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_palette_ram (
  input  logic                          clk,
  input  ptd_pkg::pal_wr_t              wr,
  input  ptd_pkg::pal_rd_t              rd,
  output logic [ptd_pkg::COLOR_W-1:0]   rd_data
);
  import ptd_pkg::*;

  logic [COLOR_W-1:0] mem [PALETTE_DEPTH];
  logic [COLOR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> src/paletted_texel_decoder.sv
// ----------------------------------------------------------------------------
// paletted_texel_decoder
// Decodes palette writes and texel data requests into 8-bit RGBA pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : requests {opcode, entry_index, data_word}. opcode 0 stores a
//            5:5:5 color in the palette, opcode 1 decodes a texel byte/word.
//   out_ch : one pixel request per cycle unless stalled {red, green, blue,
//            alpha, run_end, format_error}; run_end marks a request's last pixel.
//   cfg_*  : texel_format (index 0) and index_zero_clear (index 1); write
//            only while the block is idle.
// Pipeline: an accepted data request passes the unpack stage, the palette
//   read and the output register before its first pixel is valid.
// Throughput: the unpack stage issues one pixel per cycle while the palette
//   read stage can take it, and a request yields 4 pixels in 2bpp, 2 in 4bpp
//   and 1 otherwise; a palette write leaves it in the cycle it is written. A
//   new request is taken in the cycle the previous one issues its last pixel.
// Reset clears the pipeline valid bits and the config registers; palette
//   contents are undefined until written. When out_ch.ready is low the
//   output holds; the stages behind it fill, then stall, and drop nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module paletted_texel_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  ptd_in_if.sink                            in_ch,
  ptd_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [ptd_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [ptd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import ptd_pkg::*;

  // configuration
  logic [2:0] fmt_r;
  logic       zclr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r  <= 3'd0;
      zclr_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TEXEL_FORMAT:     fmt_r  <= cfg_wdata;
        CFG_INDEX_ZERO_CLEAR: zclr_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // stage 1: request register and pixel unpack
  logic                s1_valid_r;
  logic                s1_op_r;
  logic [INDEX_W-1:0]  s1_ent_r;
  logic [WORD_W-1:0]   s1_word_r;
  logic [1:0]          s1_sub_r;
  logic [1:0]          s1_sub_nxt;

  logic                s2_en;
  logic                s1_dec;
  logic                s1_is_wr;
  logic                s1_emit;
  logic                s1_pop;
  logic                in_fire;

  logic [INDEX_W-1:0]  pix_idx;
  logic [CHAN_W-1:0]   pix_alpha;
  logic [COLOR_W-1:0]  pix_color;
  logic                pix_use_pal;
  logic                pix_err;
  logic                pix_last;
  logic                pix_oob;
  logic [CHAN_W-1:0]   idx_alpha;
  logic [7:0]          tex_b;
  logic [2:0]          a3;

  assign tex_b = s1_word_r[7:0];
  assign a3    = tex_b[7:5];

  always_comb begin
    pix_idx     = '0;
    pix_alpha   = ALPHA_CLEAR;
    pix_color   = '0;
    pix_use_pal = 1'b1;
    pix_err     = 1'b0;
    pix_last    = 1'b1;
    case (fmt_r)
      FMT_A3I5: begin
        pix_idx   = INDEX_W'(tex_b[4:0]);
        pix_alpha = {a3, a3[2:1], 3'b000};
      end
      FMT_2BPP: begin
        case (s1_sub_r)
          2'd0:    pix_idx = INDEX_W'(tex_b[1:0]);
          2'd1:    pix_idx = INDEX_W'(tex_b[3:2]);
          2'd2:    pix_idx = INDEX_W'(tex_b[5:4]);
          default: pix_idx = INDEX_W'(tex_b[7:6]);
        endcase
        pix_alpha = idx_alpha;
        pix_last  = (s1_sub_r == 2'd3);
      end
      FMT_4BPP: begin
        pix_idx   = s1_sub_r[0] ? INDEX_W'(tex_b[7:4]) : INDEX_W'(tex_b[3:0]);
        pix_alpha = idx_alpha;
        pix_last  = (s1_sub_r == 2'd1);
      end
      FMT_8BPP: begin
        pix_idx   = tex_b;
        pix_alpha = idx_alpha;
      end
      FMT_A5I3: begin
        pix_idx   = INDEX_W'(tex_b[2:0]);
        pix_alpha = {tex_b[7:3], 3'b000};
      end
      FMT_DIRECT: begin
        pix_use_pal = 1'b0;
        pix_color   = s1_word_r[COLOR_W-1:0];
        pix_alpha   = s1_word_r[WORD_W-1] ? ALPHA_OPAQUE : ALPHA_CLEAR;
      end
      default: begin
        pix_use_pal = 1'b0;
        pix_err     = 1'b1;
      end
    endcase
  end

  assign idx_alpha = (zclr_r && pix_idx == '0) ? ALPHA_CLEAR : ALPHA_OPAQUE;
  assign pix_oob   = ({1'b0, pix_idx} >= PAL_DEPTH_W);

  assign s1_dec   = s1_valid_r && (s1_op_r == OP_DECODE);
  assign s1_is_wr = s1_valid_r && (s1_op_r == OP_PAL_WRITE);
  assign s1_emit  = s1_dec && s2_en;
  assign s1_pop   = s1_is_wr || (s1_emit && pix_last);
  assign in_fire  = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !s1_valid_r || s1_pop;

  always_comb begin
    s1_sub_nxt = s1_sub_r;
    if (in_fire) begin
      s1_sub_nxt = 2'd0;
    end else if (s1_emit) begin
      s1_sub_nxt = s1_sub_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_sub_r   <= 2'd0;
    end else begin
      s1_sub_r <= s1_sub_nxt;
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_pop) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_ch.opcode;
      s1_ent_r  <= in_ch.entry_index;
      s1_word_r <= in_ch.data_word;
    end
  end

  // palette
  pal_wr_t            pal_wr;
  pal_rd_t            pal_rd;
  logic [COLOR_W-1:0] pal_q;

  assign pal_wr.en   = s1_is_wr && ({1'b0, s1_ent_r} < PAL_DEPTH_W);
  assign pal_wr.addr = s1_ent_r[PAL_AW-1:0];
  assign pal_wr.data = s1_word_r[COLOR_W-1:0];
  assign pal_rd.en   = s2_en;
  assign pal_rd.addr = pix_idx[PAL_AW-1:0];

  ptd_palette_ram u_palette (
    .clk     (clk),
    .wr      (pal_wr),
    .rd      (pal_rd),
    .rd_data (pal_q)
  );

  // stage 2: palette read
  logic                s2_valid_r;
  logic [CHAN_W-1:0]   s2_alpha_r;
  logic [COLOR_W-1:0]  s2_color_r;
  logic                s2_use_pal_r;
  logic                s2_oob_r;
  logic                s2_err_r;
  logic                s2_last_r;
  logic                s3_en;

  assign s2_en = !s2_valid_r || s3_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_en) begin
      s2_valid_r <= s1_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_alpha_r   <= pix_alpha;
      s2_color_r   <= pix_color;
      s2_use_pal_r <= pix_use_pal;
      s2_oob_r     <= pix_oob;
      s2_err_r     <= pix_err;
      s2_last_r    <= pix_last;
    end
  end

  // stage 3: pixel format and output register
  logic                out_valid_r;
  logic [CHAN_W-1:0]   out_red_r;
  logic [CHAN_W-1:0]   out_green_r;
  logic [CHAN_W-1:0]   out_blue_r;
  logic [CHAN_W-1:0]   out_alpha_r;
  logic                out_end_r;
  logic                out_err_r;
  logic [COLOR_W-1:0]  s2_c15;

  assign s3_en  = !out_valid_r || out_ch.ready;
  assign s2_c15 = s2_use_pal_r ? (s2_oob_r ? '0 : pal_q) : s2_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_en) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      out_red_r   <= {s2_c15[4:0], 3'b000};
      out_green_r <= {s2_c15[9:5], 3'b000};
      out_blue_r  <= {s2_c15[14:10], 3'b000};
      out_alpha_r <= s2_alpha_r;
      out_end_r   <= s2_last_r;
      out_err_r   <= s2_err_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.red          = out_red_r;
  assign out_ch.green        = out_green_r;
  assign out_ch.blue         = out_blue_r;
  assign out_ch.alpha        = out_alpha_r;
  assign out_ch.run_end      = out_end_r;
  assign out_ch.format_error = out_err_r;

endmodule

`default_nettype wire

>>> src/ptd_checker.sv
// ----------------------------------------------------------------------------
// ptd_checker
// Port-level checks of the paletted texel decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ptd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ptd_pkg::CHAN_W-1:0]   red,
  input logic [ptd_pkg::CHAN_W-1:0]   green,
  input logic [ptd_pkg::CHAN_W-1:0]   blue,
  input logic [ptd_pkg::CHAN_W-1:0]   alpha,
  input logic                         run_end,
  input logic                         format_error
);
  import ptd_pkg::*;

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) && $stable(blue) && $stable(alpha) && $stable(run_end) && $stable(format_error), "stalled pixel changed")
  `ASSERT_CLK(a_err_pixel, clk, rst_n, out_valid && format_error |-> run_end && red == '0 && green == '0 && blue == '0 && alpha == '0, "error pixel not blank single")
  `ASSERT_CLK(a_low_bits, clk, rst_n, out_valid |-> red[2:0] == 3'b000 && green[2:0] == 3'b000 && blue[2:0] == 3'b000, "channel low bits set")
  `ASSERT_CLK_NR(a_reset_out, clk, !rst_n |=> !out_valid && in_ready, "pipeline not empty after reset")

endmodule

bind paletted_texel_decoder ptd_checker u_ptd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .red          (out_ch.red),
  .green        (out_ch.green),
  .blue         (out_ch.blue),
  .alpha        (out_ch.alpha),
  .run_end      (out_ch.run_end),
  .format_error (out_ch.format_error)
);

`default_nettype wire

>>> verif/tb_paletted_texel_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_paletted_texel_decoder
// Drives palette writes and texel requests through the decoder in random
// bursts. The output side stalls on its own pattern. A predictor keeps its
// own palette and register copy, and every pixel is checked field by field
// against the oldest predicted one. The run walks through all texel formats,
// the unsupported ones included, with index zero clearing both off and on.
// ----------------------------------------------------------------------------
module tb_paletted_texel_decoder;
  import ptd_pkg::*;

  localparam logic [2:0] FMT_RESERVED_0 = 3'd0;
  localparam logic [2:0] FMT_RESERVED_5 = 3'd5;
  localparam int STALL_LIMIT    = 200;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_REQUESTS = 13;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              run_end;
    logic              format_error;
  } pixel_t;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_RARE, RX_BURSTS} rx_mode_t;

  class texel_decode_model;
    logic [COLOR_W-1:0] palette [PALETTE_DEPTH];
    bit                 written [PALETTE_DEPTH];
    logic [2:0]         fmt;
    logic               izc;
    pixel_t             pending_pixels [$];
    int                 failures;

    function new();
      fmt = FMT_RESERVED_0;
      izc = 1'b0;
      failures = 0;
      foreach (palette[i]) begin
        palette[i] = '0;
        written[i] = 1'b0;
      end
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_TEXEL_FORMAT:     fmt = val;
        CFG_INDEX_ZERO_CLEAR: izc = val[0];
        default: ;
      endcase
    endfunction

    function logic [COLOR_W-1:0] lookup(int unsigned idx);
      return (idx < PALETTE_DEPTH) ? palette[idx] : '0;
    endfunction

    function logic [CHAN_W-1:0] index_alpha(int unsigned idx);
      return (izc && idx == 0) ? ALPHA_CLEAR : ALPHA_OPAQUE;
    endfunction

    function pixel_t make_pixel(logic [COLOR_W-1:0] c, logic [CHAN_W-1:0] a, logic last);
      pixel_t p;
      p.red          = {c[4:0], 3'b000};
      p.green        = {c[9:5], 3'b000};
      p.blue         = {c[14:10], 3'b000};
      p.alpha        = a;
      p.run_end      = last;
      p.format_error = 1'b0;
      return p;
    endfunction

    function void queue_pixel(pixel_t p);
      pending_pixels.insert(pending_pixels.size(), p);
    endfunction

    function void decode_request(opcode_t op, logic [INDEX_W-1:0] ent,
                                 logic [WORD_W-1:0] word);
      logic [7:0]  texel;
      logic [2:0]  a3;
      int unsigned idx;
      pixel_t      p;
      texel = word[7:0];
      if (op == OP_PAL_WRITE) begin
        if (ent < PALETTE_DEPTH) begin
          palette[ent] = word[COLOR_W-1:0];
          written[ent] = 1'b1;
        end
        return;
      end
      case (fmt)
        FMT_A3I5: begin
          a3 = texel[7:5];
          queue_pixel(make_pixel(lookup(texel[4:0]), {a3, a3[2:1], 3'b000}, 1'b1));
        end
        FMT_2BPP: begin
          for (int i = 0; i < 4; i++) begin
            idx = texel[2*i +: 2];
            queue_pixel(make_pixel(lookup(idx), index_alpha(idx), i == 3));
          end
        end
        FMT_4BPP: begin
          for (int i = 0; i < 2; i++) begin
            idx = texel[4*i +: 4];
            queue_pixel(make_pixel(lookup(idx), index_alpha(idx), i == 1));
          end
        end
        FMT_8BPP: begin
          idx = texel;
          queue_pixel(make_pixel(lookup(idx), index_alpha(idx), 1'b1));
        end
        FMT_A5I3: begin
          queue_pixel(make_pixel(lookup(texel[2:0]), {texel[7:3], 3'b000}, 1'b1));
        end
        FMT_DIRECT: begin
          queue_pixel(make_pixel(word[14:0], word[15] ? ALPHA_OPAQUE : ALPHA_CLEAR, 1'b1));
        end
        default: begin
          p = '0;
          p.run_end = 1'b1;
          p.format_error = 1'b1;
          queue_pixel(p);
        end
      endcase
    endfunction

    function bit field_ok(string name, logic [CHAN_W-1:0] want_v, logic [CHAN_W-1:0] got_v);
      if (want_v !== got_v) begin
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, name, want_v, got_v);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      bit     ok;
      if (pending_pixels.size() == 0) begin
        $display("%0t ns: unexpected pixel, expected none, actual 0x%0h", $time, got);
        failures++;
        return;
      end
      want = pending_pixels.pop_front();
      ok = 1'b1;
      ok &= field_ok("red", want.red, got.red);
      ok &= field_ok("green", want.green, got.green);
      ok &= field_ok("blue", want.blue, got.blue);
      ok &= field_ok("alpha", want.alpha, got.alpha);
      ok &= field_ok("run_end", want.run_end, got.run_end);
      ok &= field_ok("format_error", want.format_error, got.format_error);
      if (!ok)
        failures++;
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ptd_in_if  in_ch ();
  ptd_out_if out_ch ();

  paletted_texel_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  texel_decode_model model;
  int         idle_cycles = 0;
  int         burst_left;
  int         requests_sent;
  logic [2:0] cur_fmt;
  logic [2:0] phase_fmt [8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    pixel_t got;
    bit     moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        model.decode_request(opcode_t'(in_ch.opcode), in_ch.entry_index, in_ch.data_word);
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.red          = out_ch.red;
        got.green        = out_ch.green;
        got.blue         = out_ch.blue;
        got.alpha        = out_ch.alpha;
        got.run_end      = out_ch.run_end;
        got.format_error = out_ch.format_error;
        model.check_pixel(got);
        moved = 1'b1;
      end
      if (cfg_we)
        model.set_register(cfg_idx, cfg_wdata);
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  // output stall pattern, switches between randomly chosen modes
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       stall_left;
    mode = RX_ALWAYS;
    mode_left = 0;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      case (mode)
        RX_ALWAYS: out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= $urandom_range(0, 1);
        RX_RARE:   out_ch.ready <= ($urandom_range(0, 9) != 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
              stall_left = $urandom_range(4, 16);
          end
        end
      endcase
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  task automatic send_request(opcode_t op, logic [INDEX_W-1:0] ent, logic [WORD_W-1:0] word);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.entry_index <= ent;
    in_ch.data_word   <= word;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
  endtask

  // palette entries are undefined until written: fill any entry this texel reads
  task automatic send_texel(logic [WORD_W-1:0] word);
    int unsigned reads [$];
    case (cur_fmt)
      FMT_A3I5: reads.insert(reads.size(), word[4:0]);
      FMT_2BPP: for (int i = 0; i < 4; i++) reads.insert(reads.size(), word[2*i +: 2]);
      FMT_4BPP: for (int i = 0; i < 2; i++) reads.insert(reads.size(), word[4*i +: 4]);
      FMT_8BPP: reads.insert(reads.size(), word[7:0]);
      FMT_A5I3: reads.insert(reads.size(), word[2:0]);
      default: ;
    endcase
    foreach (reads[i])
      if (!model.written[reads[i]])
        send_request(OP_PAL_WRITE, INDEX_W'(reads[i]), WORD_W'($urandom_range(0, 16'hFFFF)));
    send_request(OP_DECODE, INDEX_W'($urandom_range(0, 255)), word);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (model.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_format(logic [2:0] fmt, logic izc);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_TEXEL_FORMAT;
    cfg_wdata <= fmt;
    @(posedge clk);
    cfg_idx   <= CFG_INDEX_ZERO_CLEAR;
    cfg_wdata <= CFG_DATA_W'(izc);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_fmt = fmt;
  endtask

  initial begin
    logic [2:0] fmt;
    int         target;
    model = new();
    phase_fmt = '{FMT_2BPP, FMT_A3I5, FMT_RESERVED_0, FMT_4BPP,
                  FMT_8BPP, FMT_DIRECT, FMT_A5I3, FMT_RESERVED_5};
    burst_left = 0;
    requests_sent = 0;
    cur_fmt = FMT_RESERVED_0;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_TEXEL_FORMAT;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.opcode      <= OP_PAL_WRITE;
    in_ch.entry_index <= '0;
    in_ch.data_word   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // format after reset is unsupported
    send_texel(16'h1234);
    send_request(OP_PAL_WRITE, 8'd0, 16'h0000);
    send_request(OP_PAL_WRITE, 8'd1, 16'h7FFF);
    send_request(OP_PAL_WRITE, 8'd2, 16'hFFFF);
    send_request(OP_PAL_WRITE, 8'd3, 16'h2A55);
    send_request(OP_PAL_WRITE, 8'd255, 16'h801F);

    drain();
    set_format(FMT_2BPP, 1'b1);
    send_texel(16'h00E4);
    send_texel(16'hFF00);
    drain();
    set_format(FMT_4BPP, 1'b0);
    send_texel(16'hAB30);
    send_texel(16'h0012);
    drain();
    set_format(FMT_8BPP, 1'b1);
    send_texel(16'h0000);
    // rewrite then read the same entry back to back
    send_request(OP_PAL_WRITE, 8'd255, 16'h7C00);
    send_texel(16'h00FF);
    drain();
    set_format(FMT_A3I5, 1'b0);
    send_texel(16'h00E3);
    send_texel(16'hFF00);
    drain();
    set_format(FMT_A5I3, 1'b1);
    send_texel(16'h00FB);
    send_texel(16'h5502);
    drain();
    set_format(FMT_DIRECT, 1'b0);
    send_texel(16'hFFFF);
    send_texel(16'h0000);
    send_texel(16'h7FFF);
    send_texel(16'h8000);
    drain();
    set_format(FMT_RESERVED_5, 1'b1);
    send_texel(16'hFFFF);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      fmt = (ph < 8) ? phase_fmt[ph] : 3'($urandom_range(0, 7));
      set_format(fmt, ph[0]);
      target = requests_sent + PHASE_REQUESTS;
      while (requests_sent < target) begin
        if ($urandom_range(0, 3) == 0)
          send_request(OP_PAL_WRITE,
                       INDEX_W'($urandom_range(0, 1) ? $urandom_range(0, 31)
                                                     : $urandom_range(0, 255)),
                       WORD_W'($urandom_range(0, 16'hFFFF)));
        else
          send_texel(WORD_W'($urandom_range(0, 16'hFFFF)));
      end
    end
    drain();

    if (model.failures == 0 && model.pending_pixels.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> paletted_texel_decoder.f
+incdir+src
src/ptd_pkg.sv
src/ptd_if.sv
src/ptd_palette_ram.sv
src/paletted_texel_decoder.sv
src/ptd_checker.sv
verif/tb_paletted_texel_decoder.sv
